// File: rtl/sab_pkg.sv
// Shared types and constants of the sprite alpha blitter.
// Used by the channel interfaces and by every module of the block.
package sab_pkg;

  // Field widths of the request and response channels.
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned PIX_W    = 32;
  localparam int unsigned WADDR_W  = 20;
  localparam int unsigned CHAN_W   = 8;

  // Linear screen address: a 12 bit row times a 12 bit width plus a 12 bit column.
  localparam int unsigned LIN_W    = 25;

  // Configuration register widths and reset values.
  localparam int unsigned POS_CFG_W  = 11;
  localparam int unsigned DIM_CFG_W  = 12;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;

  localparam logic [DIM_CFG_W-1:0] RST_SPRITE_DIM    = 12'd1;
  localparam logic [DIM_CFG_W-1:0] RST_SCREEN_WIDTH  = 12'd1280;
  localparam logic [DIM_CFG_W-1:0] RST_SCREEN_HEIGHT = 12'd720;

  // Largest channel value, also the blend divisor.
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  // Job queue between the front and back parts (depth is a power of two).
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request opcodes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_BLEND = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } sab_op_e;

  // Work the back part carries out for one request.
  typedef enum logic [1:0] {
    JOB_REPORT = 2'd0,
    JOB_LOAD   = 2'd1,
    JOB_READ   = 2'd2,
    JOB_BLEND  = 2'd3
  } sab_job_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DEST_X        = 3'd0,
    REG_DEST_Y        = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5
  } sab_reg_e;

  typedef struct packed {
    logic [POS_CFG_W-1:0] dest_x;
    logic [POS_CFG_W-1:0] dest_y;
    logic [DIM_CFG_W-1:0] sprite_width;
    logic [DIM_CFG_W-1:0] sprite_height;
    logic [DIM_CFG_W-1:0] screen_width;
    logic [DIM_CFG_W-1:0] screen_height;
  } sab_cfg_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    sab_job_e           job;
    logic [LIN_W-1:0]   fb_addr;
    logic [WADDR_W-1:0] addr_out;
    logic [PIX_W-1:0]   pixel;
    logic               done;
  } sab_job_t;

  // Truncating division by 255 for products of two channel values (x <= 65025).
  function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
    logic [2*CHAN_W:0] sum;
    sum = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[2*CHAN_W-1:CHAN_W]} + 17'd1;
    return sum[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

// File: rtl/sab_if.sv
// Request and response channel interfaces of the sprite alpha blitter.
// Depends on sab_pkg for the field widths.
interface sab_req_if import sab_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OPCODE_W-1:0] opcode;
  logic [PIX_W-1:0]    pixel_in;
  logic [WADDR_W-1:0]  word_address;

  modport source (output valid, output opcode, output pixel_in, output word_address,
                  input ready);
  modport sink   (input valid, input opcode, input pixel_in, input word_address,
                  output ready);
endinterface

interface sab_rsp_if import sab_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_out;
  logic [WADDR_W-1:0] address_out;
  logic               written;
  logic               sprite_done;

  modport source (output valid, output pixel_out, output address_out, output written,
                  output sprite_done, input ready);
  modport sink   (input valid, input pixel_out, input address_out, input written,
                  input sprite_done, output ready);
endinterface

// File: rtl/sab_front.sv
// Front part: accepts requests, steps the sprite counters and classifies each request
// into a job with its frame-buffer address. Depends on sab_pkg and sab_req_if.
module sab_front import sab_pkg::*; #(
  parameter int unsigned FRAME_WORDS = 1048576,
  parameter int unsigned MAX_DIM     = 2048
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sab_req_if.sink    req_i,
  input  sab_cfg_t   cfg_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output sab_job_t   push_job_o
);

  localparam int unsigned CW    = $clog2(MAX_DIM);
  localparam int unsigned DW    = CW + 1;
  localparam int unsigned POS_W = ((CW > POS_CFG_W) ? CW : POS_CFG_W) + 1;
  localparam logic [LIN_W-1:0] FRAME_LIMIT = LIN_W'(FRAME_WORDS);

  logic                 accept;
  logic [CW-1:0]        col_q, col_d;
  logic [CW-1:0]        row_q, row_d;
  logic [DW-1:0]        w_eff, h_eff;
  logic [POS_W-1:0]     scr_col, scr_row;
  logic                 col_wrap, row_wrap;
  logic                 on_screen, in_range, done_d;

  logic                 f_valid_q;
  sab_op_e              f_op_q;
  logic [PIX_W-1:0]     f_pixel_q;
  logic [WADDR_W-1:0]   f_waddr_q;
  logic                 f_in_range_q;
  logic                 f_on_screen_q;
  logic [DIM_CFG_W-1:0] f_col_q, f_row_q;
  logic                 f_done_q;

  logic [2*DIM_CFG_W-1:0] prod;
  logic [LIN_W-1:0]       lin;
  logic                   lin_ok;

  // The stage register takes a request whenever it is empty or hands its job on.
  assign req_i.ready = !f_valid_q || push_ready_i;
  assign accept      = req_i.valid && req_i.ready;

  // Sprite size as used: zero acts as one, large values clamp to the maximum.
  always_comb begin
    if (cfg_i.sprite_width == '0) begin
      w_eff = DW'(1);
    end else if (32'(cfg_i.sprite_width) > 32'(MAX_DIM)) begin
      w_eff = DW'(MAX_DIM);
    end else begin
      w_eff = DW'(cfg_i.sprite_width);
    end
    if (cfg_i.sprite_height == '0) begin
      h_eff = DW'(1);
    end else if (32'(cfg_i.sprite_height) > 32'(MAX_DIM)) begin
      h_eff = DW'(MAX_DIM);
    end else begin
      h_eff = DW'(cfg_i.sprite_height);
    end
  end

  // Screen position of the current sprite pixel and the raster counter step.
  always_comb begin
    scr_col   = POS_W'(cfg_i.dest_x) + POS_W'(col_q);
    scr_row   = POS_W'(cfg_i.dest_y) + POS_W'(row_q);
    on_screen = (scr_col < POS_W'(cfg_i.screen_width)) &&
                (scr_row < POS_W'(cfg_i.screen_height));
    in_range  = LIN_W'(req_i.word_address) < FRAME_LIMIT;
    col_wrap  = (DW'(col_q) + DW'(1)) >= w_eff;
    row_wrap  = (DW'(row_q) + DW'(1)) >= h_eff;
    col_d     = col_q;
    row_d     = row_q;
    done_d    = 1'b0;
    if (col_wrap) begin
      col_d = '0;
      if (row_wrap) begin
        row_d  = '0;
        done_d = 1'b1;
      end else begin
        row_d = CW'(row_q + CW'(1));
      end
    end else begin
      col_d = CW'(col_q + CW'(1));
    end
  end

  // Sprite counters advance on every accepted blend.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept && (sab_op_e'(req_i.opcode) == OP_BLEND)) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (accept) begin
      f_valid_q <= 1'b1;
    end else if (push_ready_i) begin
      f_valid_q <= 1'b0;
    end
  end

  // Stage register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_op_q        <= sab_op_e'(req_i.opcode);
      f_pixel_q     <= req_i.pixel_in;
      f_waddr_q     <= req_i.word_address;
      f_in_range_q  <= in_range;
      f_on_screen_q <= on_screen;
      f_col_q       <= scr_col[DIM_CFG_W-1:0];
      f_row_q       <= scr_row[DIM_CFG_W-1:0];
      f_done_q      <= (sab_op_e'(req_i.opcode) == OP_BLEND) && done_d;
    end
  end

  // Linear address of the blend pixel and classification into a job.
  always_comb begin
    prod   = f_row_q * cfg_i.screen_width;
    lin    = LIN_W'(prod) + LIN_W'(f_col_q);
    lin_ok = lin < FRAME_LIMIT;

    push_job_o.pixel    = f_pixel_q;
    push_job_o.done     = f_done_q;
    push_job_o.job      = JOB_REPORT;
    push_job_o.fb_addr  = LIN_W'(f_waddr_q);
    push_job_o.addr_out = f_waddr_q;
    case (f_op_q)
      OP_LOAD: begin
        if (f_in_range_q) push_job_o.job = JOB_LOAD;
      end
      OP_READ: begin
        if (f_in_range_q) push_job_o.job = JOB_READ;
      end
      OP_BLEND: begin
        push_job_o.fb_addr = lin;
        if (f_on_screen_q && lin_ok) begin
          push_job_o.job      = JOB_BLEND;
          push_job_o.addr_out = lin[WADDR_W-1:0];
        end else begin
          push_job_o.addr_out = '0;
        end
      end
      default: begin
        push_job_o.addr_out = '0;
      end
    endcase
  end

  assign push_valid_o = f_valid_q;

endmodule

// File: rtl/sab_queue.sv
// Short job queue that decouples the front part from the back part.
// Depends on sab_pkg for the job type and the queue depth.
module sab_queue import sab_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  sab_job_t push_job_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output sab_job_t pop_job_o
);

  sab_job_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = count_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_job_o    = entry_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= QPTR_W'(wr_ptr_q + QPTR_W'(1));
      if (pop)  rd_ptr_q <= QPTR_W'(rd_ptr_q + QPTR_W'(1));
      if (push && !pop) begin
        count_q <= QCNT_W'(count_q + QCNT_W'(1));
      end else if (pop && !push) begin
        count_q <= QCNT_W'(count_q - QCNT_W'(1));
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_job_i;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("job queue holds more entries than its depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ready_i && !pop_valid_o && !push |=> count_q == $past(count_q))
    else $error("job queue count changed on a pop from an empty queue");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == QCNT_W'($past(count_q) + QCNT_W'(1)))
    else $error("job queue count did not grow on a push");
`endif

endmodule

// File: rtl/sab_back.sv
// Back part: holds the frame buffer, reads the background, blends and writes back,
// and drives the response register. Depends on sab_pkg and sab_rsp_if.
module sab_back import sab_pkg::*; #(
  parameter int unsigned FRAME_WORDS = 1048576
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pop_valid_i,
  output logic     pop_ready_o,
  input  sab_job_t pop_job_i,
  sab_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(FRAME_WORDS);

  logic [PIX_W-1:0] frame_mem [FRAME_WORDS];

  logic             s1_valid_q;
  sab_job_t         s1_q;
  logic [PIX_W-1:0] rd_data_q;
  logic             s1_adv, pop;
  logic             wr_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [PIX_W-1:0] wr_data, blend_word;

  logic [CHAN_W-1:0]   alpha, alpha_inv;
  logic [CHAN_W-1:0]   src_c [3];
  logic [CHAN_W-1:0]   dst_c [3];
  logic [2*CHAN_W-1:0] src_p [3];
  logic [2*CHAN_W-1:0] dst_p [3];
  logic [CHAN_W:0]     mix_c [3];

  logic               out_valid_q;
  logic [PIX_W-1:0]   out_pixel_q;
  logic [WADDR_W-1:0] out_addr_q;
  logic               out_written_q, out_done_q;

  // Blend stage moves on when the response register is free or being taken.
  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign pop_ready_o = !s1_valid_q || s1_adv;
  assign pop         = pop_valid_i && pop_ready_o;

  // Source-over blend of the three color channels, written back with alpha zero.
  always_comb begin
    alpha      = s1_q.pixel[PIX_W-1 -: CHAN_W];
    alpha_inv  = CHAN_MAX - alpha;
    blend_word = '0;
    for (int i = 0; i < 3; i++) begin
      src_c[i] = s1_q.pixel[CHAN_W*i +: CHAN_W];
      dst_c[i] = rd_data_q[CHAN_W*i +: CHAN_W];
      src_p[i] = {{CHAN_W{1'b0}}, src_c[i]} * {{CHAN_W{1'b0}}, alpha};
      dst_p[i] = {{CHAN_W{1'b0}}, dst_c[i]} * {{CHAN_W{1'b0}}, alpha_inv};
      mix_c[i] = {1'b0, div255(src_p[i])} + {1'b0, div255(dst_p[i])};
      blend_word[CHAN_W*i +: CHAN_W] = mix_c[i][CHAN_W-1:0];
    end
  end

  // Frame-buffer write port, used by loads and blends as they leave the stage.
  assign wr_en   = s1_adv && ((s1_q.job == JOB_LOAD) || (s1_q.job == JOB_BLEND));
  assign wr_addr = AW'(s1_q.fb_addr);
  assign wr_data = (s1_q.job == JOB_LOAD) ? s1_q.pixel : blend_word;
  assign rd_addr = AW'(pop_job_i.fb_addr);

  always_ff @(posedge clk_i) begin
    if (wr_en) frame_mem[wr_addr] <= wr_data;
  end

  // Read port; the word written at the same edge is forwarded.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_q <= wr_data;
      end else begin
        rd_data_q <= frame_mem[rd_addr];
      end
    end
  end

  // Blend stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pop) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) s1_q <= pop_job_i;
  end

  // Response register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Response payload by job.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_addr_q <= s1_q.addr_out;
      out_done_q <= s1_q.done;
      case (s1_q.job)
        JOB_LOAD: begin
          out_pixel_q   <= '0;
          out_written_q <= 1'b1;
        end
        JOB_READ: begin
          out_pixel_q   <= rd_data_q;
          out_written_q <= 1'b0;
        end
        JOB_BLEND: begin
          out_pixel_q   <= blend_word;
          out_written_q <= 1'b1;
        end
        default: begin
          out_pixel_q   <= '0;
          out_written_q <= 1'b0;
        end
      endcase
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.pixel_out   = out_pixel_q;
  assign rsp_o.address_out = out_addr_q;
  assign rsp_o.written     = out_written_q;
  assign rsp_o.sprite_done = out_done_q;

`ifndef ASSERT_OFF
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> $stable(rd_data_q))
    else $error("background word changed while the blend stage was stalled");
`endif

endmodule

// File: rtl/sprite_alpha_blit.sv
// Sprite alpha blitter top level: configuration registers, front, job queue and back.
// Depends on sab_pkg, sab_if, sab_front, sab_queue and sab_back.
//
// The block takes one request per clock and returns one response per request, in
// order: a load writes a frame-buffer word, a read returns one, and a blend takes the
// next sprite pixel in raster order, reads the background under it, mixes each color
// channel with the source alpha and writes the result back with alpha zero. Sustained
// rate is one request per cycle only while responses are taken; a request passes the
// front register, job queue, blend stage and response register in turn. The
// frame buffer has one read and one write port; a blend's read-modify-write takes one
// pass through the blend stage, and a word written by one request is forwarded to the
// next. Off-screen blend pixels still advance the sprite counters but write nothing.
// The frame buffer is not cleared after reset: a word must be loaded before it is read
// or blended over. Write configuration registers only while no request is in flight.
module sprite_alpha_blit import sab_pkg::*; #(
  parameter int unsigned FRAME_WORDS = 1048576,
  parameter int unsigned MAX_DIM     = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sab_req_if.sink               req_i,
  sab_rsp_if.source             rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  sab_cfg_t cfg_q;
  logic     cfg_wr;
  sab_reg_e cfg_idx;

  logic     push_valid, push_ready, pop_valid, pop_ready;
  sab_job_t push_job, pop_job;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = sab_reg_e'(paddr[APB_ADDR_W-1:2]);

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x        <= '0;
      cfg_q.dest_y        <= '0;
      cfg_q.sprite_width  <= RST_SPRITE_DIM;
      cfg_q.sprite_height <= RST_SPRITE_DIM;
      cfg_q.screen_width  <= RST_SCREEN_WIDTH;
      cfg_q.screen_height <= RST_SCREEN_HEIGHT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEST_X:        cfg_q.dest_x        <= pwdata[POS_CFG_W-1:0];
        REG_DEST_Y:        cfg_q.dest_y        <= pwdata[POS_CFG_W-1:0];
        REG_SPRITE_WIDTH:  cfg_q.sprite_width  <= pwdata[DIM_CFG_W-1:0];
        REG_SPRITE_HEIGHT: cfg_q.sprite_height <= pwdata[DIM_CFG_W-1:0];
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[DIM_CFG_W-1:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[DIM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    case (cfg_idx)
      REG_DEST_X:        prdata = APB_DATA_W'(cfg_q.dest_x);
      REG_DEST_Y:        prdata = APB_DATA_W'(cfg_q.dest_y);
      REG_SPRITE_WIDTH:  prdata = APB_DATA_W'(cfg_q.sprite_width);
      REG_SPRITE_HEIGHT: prdata = APB_DATA_W'(cfg_q.sprite_height);
      REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(cfg_q.screen_width);
      REG_SCREEN_HEIGHT: prdata = APB_DATA_W'(cfg_q.screen_height);
      default:           prdata = '0;
    endcase
  end

  sab_front #(
    .FRAME_WORDS (FRAME_WORDS),
    .MAX_DIM     (MAX_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  sab_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  sab_back #(
    .FRAME_WORDS (FRAME_WORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .rsp_o       (rsp_o)
  );

endmodule
